@@ sv/mwo_pkg.sv @@
// shared constants, state encoding and wavetable builders for the oscillator
package mwo_pkg;

  localparam int MODE_W         = 3;
  localparam int PHASE_W        = 23;
  localparam int SAMPLE_W       = 16;
  localparam int FRAC_BITS      = 12;
  localparam int TABLE_DEPTH    = 1024;
  localparam int ADDR_W         = $clog2(TABLE_DEPTH);
  localparam int HARMONIC_COUNT = 16;
  localparam int LAST_W         = PHASE_W - 1;
  localparam int LFSR_W         = 32;
  localparam int LFSR_STEPS     = 8;
  localparam int RND_CYCLES     = LFSR_W / LFSR_STEPS;
  localparam int RND_CNT_W      = $clog2(RND_CYCLES);

  localparam logic [MODE_W-1:0] MODE_SINE     = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_SAW      = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_SQUARE   = MODE_W'(2);
  localparam logic [MODE_W-1:0] MODE_TRIANGLE = MODE_W'(3);
  localparam logic [MODE_W-1:0] MODE_RANDOM   = MODE_W'(4);

  // parabolic sine coefficients in Q16
  localparam logic signed [31:0] COEF_A = 32'sd83443;
  localparam logic signed [31:0] COEF_B = 32'sd26561;
  localparam logic signed [31:0] COEF_C = 32'sd14746;

  localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h8020_0003;
  localparam logic [ADDR_W-1:0] HALF_IDX  = ADDR_W'(TABLE_DEPTH / 2);

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam logic [63:0] DEPTH_W64   = 64'(TABLE_DEPTH);

  typedef logic signed [SAMPLE_W-1:0] rom_t [TABLE_DEPTH];

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SIN_A,
    ST_SIN_SQ,
    ST_SIN_BL,
    ST_SIN_BH,
    ST_SIN_P,
    ST_SIN_T,
    ST_SIN_Y0,
    ST_SIN_Y,
    ST_SIN_YY,
    ST_SIN_Z,
    ST_SIN_ZC,
    ST_SIN_W,
    ST_ROM_RD,
    ST_ROM_MUL,
    ST_ROM_SUM1,
    ST_ROM_SUM2,
    ST_RND_CMP,
    ST_RND_STEP,
    ST_OUT
  } state_t;

  // sin(2*pi*p/depth) in signed Q30, taylor series on a quarter wave
  function automatic logic signed [63:0] rom_sine(input logic [63:0] p);
    logic [63:0] a;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] f;
    logic [63:0] t;
    logic [63:0] s;
    logic        neg;
    int          k;
    a   = p << 2;
    neg = 1'b0;
    if (a >= (DEPTH_W64 << 1)) begin
      a   = a - (DEPTH_W64 << 1);
      neg = 1'b1;
    end
    if (a > DEPTH_W64) begin
      a = (DEPTH_W64 << 1) - a;
    end
    x  = (a * HALF_PI_Q30) / DEPTH_W64;
    x2 = (x * x) >> 30;
    f  = ONE_Q30;
    for (k = 0; k < 5; k++) begin
      t = (x2 * f) >> 30;
      case (k)
        0:       t = t / 64'd110;
        1:       t = t / 64'd72;
        2:       t = t / 64'd42;
        3:       t = t / 64'd20;
        default: t = t / 64'd6;
      endcase
      f = ONE_Q30 - t;
    end
    s = (x * f) >> 30;
    return neg ? -$signed(s) : $signed(s);
  endfunction

  // restoring long division for the harmonic weights
  function automatic logic [31:0] udiv32(input logic [31:0] num, input logic [12:0] den);
    logic [32:0] rem;
    logic [31:0] quo;
    int          i;
    rem = '0;
    quo = '0;
    for (i = 31; i >= 0; i--) begin
      rem = {rem[31:0], num[i]};
      if (rem >= {20'd0, den}) begin
        rem    = rem - {20'd0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // one table entry: band-limited saw or triangle harmonic sum
  function automatic logic signed [SAMPLE_W-1:0] rom_entry(input int idx,
                                                           input logic tri_sel);
    logic signed [63:0] s;
    logic signed [63:0] acc;
    logic signed [63:0] rnd;
    logic [63:0]        m;
    logic [31:0]        q;
    logic [12:0]        dv;
    logic               minus;
    int                 n;
    acc = '0;
    for (n = 1; n <= HARMONIC_COUNT; n++) begin
      s = rom_sine(64'((n * idx) % TABLE_DEPTH));
      m = (s < 0) ? 64'(-s) : 64'(s);
      if (!tri_sel) begin
        dv    = 13'(n);
        q     = udiv32(32'(m + 64'(n >> 1)), dv);
        minus = (s < 0) != ((n & 1) == 0);
        acc   = minus ? acc - $signed({32'd0, q}) : acc + $signed({32'd0, q});
      end else if ((n & 1) == 1) begin
        dv    = 13'(n * n);
        q     = udiv32(32'(m + 64'((n * n) >> 1)), dv);
        minus = (s < 0) != ((((n - 1) >> 1) & 1) == 1);
        acc   = minus ? acc - $signed({32'd0, q}) : acc + $signed({32'd0, q});
      end
    end
    rnd = (acc + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    if (rnd > 64'sd32767) begin
      rnd = 64'sd32767;
    end else if (rnd < -64'sd32768) begin
      rnd = -64'sd32768;
    end
    return SAMPLE_W'(rnd);
  endfunction

  function automatic rom_t build_rom(input logic tri_sel);
    rom_t r;
    int   i;
    for (i = 0; i < TABLE_DEPTH; i++) begin
      r[i] = rom_entry(i, tri_sel);
    end
    return r;
  endfunction

endpackage

@@ sv/multi_waveform_oscillator.sv @@
// five-mode oscillator: parabolic sine, wavetable saw/square/triangle, random hold
//
//   channel | signals                          | moves
//   --------+----------------------------------+-------------------------------
//   in      | in_valid, in_ready, mode, phase  | one waveform request per transfer
//   out     | out_valid, out_ready, sample     | one Q3.12 sample per transfer
//
// random hold draws a new value only when the phase wraps; other mode codes go
// straight to the output with a zero sample.
// the sine path is a chain of twelve steps, six of them through the one shared
// 32x32 multiplier; square takes two rounds of two-port wavetable reads; random draws
// come from the lfsr, advanced 8 shifts per cycle while in its step state.
// synchronous reset clears the sequencer, the output valid flag, the held value,
// the last phase and the draw counter, and seeds the lfsr with 1; the wavetables are roms and need no clearing.
// a finished sample sits in the output register; the next request is taken
// while it waits, and a sample that finds the register still full waits in ST_OUT.
module multi_waveform_oscillator (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic        [mwo_pkg::MODE_W-1:0]    mode,
  input  logic signed [mwo_pkg::PHASE_W-1:0]   phase,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [mwo_pkg::SAMPLE_W-1:0]  sample
);

  localparam int F      = mwo_pkg::FRAC_BITS;
  localparam int PW     = mwo_pkg::PHASE_W;
  localparam int SW     = mwo_pkg::SAMPLE_W;
  localparam int AW     = mwo_pkg::ADDR_W;
  localparam int LW     = mwo_pkg::LFSR_W;
  localparam int SIN_SH = 16 - F;

  localparam logic signed [48:0] Y_LIM = 49'sd1 <<< 22;
  localparam logic [mwo_pkg::RND_CNT_W-1:0] RND_LAST =
    mwo_pkg::RND_CNT_W'(mwo_pkg::RND_CYCLES - 1);

  // wavetables, built at elaboration
  localparam mwo_pkg::rom_t SAW_ROM = mwo_pkg::build_rom(1'b0);
  localparam mwo_pkg::rom_t TRI_ROM = mwo_pkg::build_rom(1'b1);

  function automatic logic signed [SW-1:0] sat16(input logic signed [31:0] v);
    if (v > 32'sd32767) begin
      return 16'sh7fff;
    end else if (v < -32'sd32768) begin
      return 16'sh8000;
    end
    return SW'(v);
  endfunction

  // galois right shift, several steps per call
  function automatic logic [LW-1:0] lfsr_adv(input logic [LW-1:0] v);
    logic [LW-1:0] r;
    int            k;
    r = v;
    for (k = 0; k < mwo_pkg::LFSR_STEPS; k++) begin
      r = r[0] ? ((r >> 1) ^ mwo_pkg::LFSR_TAPS) : (r >> 1);
    end
    return r;
  endfunction

  mwo_pkg::state_t state;
  mwo_pkg::state_t state_next;

  // request registers
  logic        [mwo_pkg::MODE_W-1:0] mode_r;
  logic signed [PW-1:0]              x_r;
  logic signed [SW-1:0]              res;

  // shared multiplier
  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] mul_p;
  logic signed [63:0] prod;

  // sine working registers
  logic signed [40:0] ya;
  logic        [21:0] sq_hi;
  logic        [37:0] plo;
  logic        [58:0] pbig;
  logic signed [47:0] tq;
  logic signed [48:0] y0;
  logic signed [23:0] yv;
  logic signed [30:0] zv;

  // wavetable path
  logic              rom_flip;
  logic signed [PW-1:0] ip;
  logic [AW-1:0]     idx;
  logic [AW-1:0]     addr_lo;
  logic [AW-1:0]     addr_hi;
  logic [F-1:0]      frac;
  logic signed [SW-1:0] saw_lo;
  logic signed [SW-1:0] saw_hi;
  logic signed [SW-1:0] tri_lo;
  logic signed [SW-1:0] tri_hi;
  logic signed [SW-1:0] d_lo;
  logic signed [SW-1:0] d_hi;
  logic signed [16:0]   diff;
  logic signed [29:0]   ipr;
  logic signed [29:0]   irnd;
  logic signed [17:0]   vsum;
  logic signed [SW-1:0] base;
  logic signed [SW-1:0] v1;

  // random hold
  logic [LW-1:0]                  lfsr;
  logic [LW-1:0]                  lfsr_nx;
  logic [mwo_pkg::RND_CNT_W-1:0]  rnd_cnt;
  logic signed [SW-1:0]           held;
  logic [mwo_pkg::LAST_W-1:0]     last_phase;
  logic [mwo_pkg::LAST_W-1:0]     cp;
  logic                           draw;
  logic [F:0]                     top;
  logic signed [SW-1:0]           draw_val;

  // sine combinational pieces
  logic        [PW-1:0] ax;
  logic        [22:0]   ay;
  logic signed [59:0]   t_sgn;
  logic signed [59:0]   t_shift;
  logic signed [48:0]   y_shift;
  logic signed [23:0]   y_clamp;
  logic signed [45:0]   p46;
  logic signed [45:0]   p46_shift;
  logic signed [31:0]   w_sum;
  logic signed [31:0]   w_rnd;

  logic out_free;

  assign in_ready = (state == mwo_pkg::ST_IDLE);
  assign out_free = !out_valid || out_ready;

  assign mul_p = mul_a * mul_b;

  // sine datapath
  assign ax      = x_r[PW-1] ? PW'(-x_r) : PW'(x_r);
  assign ay      = yv[23] ? 23'(-yv) : 23'(yv);
  assign t_sgn   = x_r[PW-1] ? -$signed({1'b0, pbig}) : $signed({1'b0, pbig});
  assign t_shift = (t_sgn + (60'sd1 <<< (F - 1))) >>> F;
  assign y_shift = (y0 + (49'sd1 <<< (F - 1))) >>> F;
  assign p46     = prod[45:0];
  assign p46_shift = (p46 + (46'sd1 <<< 15)) >>> 16;
  assign w_sum   = 32'(p46_shift) + 32'(yv);
  assign w_rnd   = (w_sum + (32'sd1 <<< (SIN_SH - 1))) >>> SIN_SH;

  always_comb begin
    if (y_shift > Y_LIM) begin
      y_clamp = 24'(Y_LIM);
    end else if (y_shift < -Y_LIM) begin
      y_clamp = 24'(-Y_LIM);
    end else begin
      y_clamp = 24'(y_shift);
    end
  end

  // wavetable addressing: floor of the phase, wrapped to the table
  assign ip      = x_r >>> F;
  assign idx     = ip[AW-1:0];
  assign frac    = x_r[F-1:0];
  assign addr_lo = rom_flip ? (idx ^ mwo_pkg::HALF_IDX) : idx;
  assign addr_hi = AW'(addr_lo + 1'b1);

  assign d_lo = (mode_r == mwo_pkg::MODE_TRIANGLE) ? tri_lo : saw_lo;
  assign d_hi = (mode_r == mwo_pkg::MODE_TRIANGLE) ? tri_hi : saw_hi;
  assign diff = 17'(d_hi) - 17'(d_lo);
  assign ipr  = prod[29:0];
  assign irnd = (ipr + (30'sd1 <<< (F - 1))) >>> F;
  assign vsum = 18'(base) + 18'(irnd);

  // random hold: clamp negative phase, draw on wrap
  assign cp       = x_r[PW-1] ? '0 : x_r[mwo_pkg::LAST_W-1:0];
  assign draw     = cp < last_phase;
  assign lfsr_nx  = lfsr_adv(lfsr);
  assign top      = lfsr_nx[LW-1 -: F+1];
  assign draw_val = SW'($signed({~top[F], top[F-1:0]}));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mwo_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (mode)
            mwo_pkg::MODE_SINE:     state_next = mwo_pkg::ST_SIN_A;
            mwo_pkg::MODE_SAW:      state_next = mwo_pkg::ST_ROM_RD;
            mwo_pkg::MODE_SQUARE:   state_next = mwo_pkg::ST_ROM_RD;
            mwo_pkg::MODE_TRIANGLE: state_next = mwo_pkg::ST_ROM_RD;
            mwo_pkg::MODE_RANDOM:   state_next = mwo_pkg::ST_RND_CMP;
            default:                state_next = mwo_pkg::ST_OUT;
          endcase
        end
      end
      mwo_pkg::ST_SIN_A:   state_next = mwo_pkg::ST_SIN_SQ;
      mwo_pkg::ST_SIN_SQ:  state_next = mwo_pkg::ST_SIN_BL;
      mwo_pkg::ST_SIN_BL:  state_next = mwo_pkg::ST_SIN_BH;
      mwo_pkg::ST_SIN_BH:  state_next = mwo_pkg::ST_SIN_P;
      mwo_pkg::ST_SIN_P:   state_next = mwo_pkg::ST_SIN_T;
      mwo_pkg::ST_SIN_T:   state_next = mwo_pkg::ST_SIN_Y0;
      mwo_pkg::ST_SIN_Y0:  state_next = mwo_pkg::ST_SIN_Y;
      mwo_pkg::ST_SIN_Y:   state_next = mwo_pkg::ST_SIN_YY;
      mwo_pkg::ST_SIN_YY:  state_next = mwo_pkg::ST_SIN_Z;
      mwo_pkg::ST_SIN_Z:   state_next = mwo_pkg::ST_SIN_ZC;
      mwo_pkg::ST_SIN_ZC:  state_next = mwo_pkg::ST_SIN_W;
      mwo_pkg::ST_SIN_W:   state_next = mwo_pkg::ST_OUT;
      mwo_pkg::ST_ROM_RD:  state_next = mwo_pkg::ST_ROM_MUL;
      mwo_pkg::ST_ROM_MUL: state_next = mwo_pkg::ST_ROM_SUM1;
      mwo_pkg::ST_ROM_SUM1: begin
        state_next = (mode_r == mwo_pkg::MODE_SQUARE) ? mwo_pkg::ST_ROM_SUM2
                                                      : mwo_pkg::ST_OUT;
      end
      mwo_pkg::ST_ROM_SUM2: state_next = mwo_pkg::ST_OUT;
      mwo_pkg::ST_RND_CMP: begin
        state_next = draw ? mwo_pkg::ST_RND_STEP : mwo_pkg::ST_OUT;
      end
      mwo_pkg::ST_RND_STEP: begin
        if (rnd_cnt == RND_LAST) begin
          state_next = mwo_pkg::ST_OUT;
        end
      end
      mwo_pkg::ST_OUT: begin
        if (out_free) begin
          state_next = mwo_pkg::ST_IDLE;
        end
      end
      default: state_next = mwo_pkg::ST_IDLE;
    endcase
  end

  // per-step multiplier operands and table address offset
  always_comb begin
    mul_a    = '0;
    mul_b    = '0;
    rom_flip = 1'b0;
    case (state)
      mwo_pkg::ST_SIN_A: begin
        mul_a = mwo_pkg::COEF_A;
        mul_b = 32'(x_r);
      end
      mwo_pkg::ST_SIN_SQ: begin
        mul_a = 32'(ax);
        mul_b = 32'(ax);
      end
      mwo_pkg::ST_SIN_BL: begin
        mul_a = mwo_pkg::COEF_B;
        mul_b = 32'(prod[22:0]);
      end
      mwo_pkg::ST_SIN_BH: begin
        mul_a = mwo_pkg::COEF_B;
        mul_b = 32'(sq_hi);
      end
      mwo_pkg::ST_SIN_YY: begin
        mul_a = 32'(yv);
        mul_b = 32'(ay);
      end
      mwo_pkg::ST_SIN_ZC: begin
        mul_a = 32'(zv);
        mul_b = mwo_pkg::COEF_C;
      end
      mwo_pkg::ST_ROM_MUL: begin
        mul_a    = 32'(diff);
        mul_b    = 32'(frac);
        rom_flip = 1'b1;
      end
      mwo_pkg::ST_ROM_SUM1: begin
        mul_a = 32'(diff);
        mul_b = 32'(frac);
      end
      default: ;
    endcase
  end

  // control and oscillator state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= mwo_pkg::ST_IDLE;
      out_valid  <= 1'b0;
      held       <= '0;
      last_phase <= '0;
      lfsr       <= LW'(1);
      rnd_cnt    <= '0;
    end else begin
      state <= state_next;
      if (state == mwo_pkg::ST_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == mwo_pkg::ST_RND_CMP) begin
        last_phase <= cp;
        rnd_cnt    <= '0;
      end
      if (state == mwo_pkg::ST_RND_STEP) begin
        lfsr    <= lfsr_nx;
        rnd_cnt <= rnd_cnt + 1'b1;
        if (rnd_cnt == RND_LAST) begin
          held <= draw_val;
        end
      end
    end
  end

  // wavetable roms, two read ports each, registered data
  always_ff @(posedge clk) begin
    saw_lo <= SAW_ROM[addr_lo];
    saw_hi <= SAW_ROM[addr_hi];
    tri_lo <= TRI_ROM[addr_lo];
    tri_hi <= TRI_ROM[addr_hi];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_p;
    if (state == mwo_pkg::ST_OUT && out_free) begin
      sample <= res;
    end
    case (state)
      mwo_pkg::ST_IDLE: begin
        if (in_valid) begin
          mode_r <= mode;
          x_r    <= phase;
          res    <= '0;
        end
      end
      mwo_pkg::ST_SIN_SQ: ya    <= prod[40:0];
      mwo_pkg::ST_SIN_BL: sq_hi <= prod[44:23];
      mwo_pkg::ST_SIN_BH: plo   <= prod[37:0];
      mwo_pkg::ST_SIN_P:  pbig  <= {prod[35:0], 23'd0} + 59'(plo);
      mwo_pkg::ST_SIN_T:  tq    <= 48'(t_shift);
      mwo_pkg::ST_SIN_Y0: y0    <= 49'(ya) - 49'(tq);
      mwo_pkg::ST_SIN_Y:  yv    <= y_clamp;
      mwo_pkg::ST_SIN_Z:  zv    <= 31'(p46_shift) - 31'(yv);
      mwo_pkg::ST_SIN_W:  res   <= sat16(w_rnd);
      mwo_pkg::ST_ROM_MUL: base <= d_lo;
      mwo_pkg::ST_ROM_SUM1: begin
        // second pair of reads (half a table away) lands here for square
        base <= d_lo;
        if (mode_r == mwo_pkg::MODE_SQUARE) begin
          v1 <= SW'(vsum);
        end else begin
          res <= SW'(vsum);
        end
      end
      mwo_pkg::ST_ROM_SUM2: res <= sat16(32'(v1) - 32'(vsum));
      mwo_pkg::ST_RND_CMP: begin
        if (!draw) begin
          res <= held;
        end
      end
      mwo_pkg::ST_RND_STEP: begin
        if (rnd_cnt == RND_LAST) begin
          res <= draw_val;
        end
      end
      default: ;
    endcase
  end

endmodule
